/* hw/rtl/csl_pkg.sv */
// Shared types and constants for the C subset lexer: token kinds, lexer modes and
// the result record that travels from the front end through the queue to the back end.
// No dependencies.
package csl_pkg;

    localparam int LINE_BITS_DEF   = 16;
    localparam int COLUMN_BITS_DEF = 12;
    localparam int MAX_RESULTS     = 4;
    localparam int QUEUE_DEPTH     = 4;
    localparam int RES_IDX_BITS    = $clog2(MAX_RESULTS);

    typedef enum logic [3:0] {
        KIND_TEXT   = 4'd0,
        KIND_PUNCT  = 4'd1,
        KIND_EQ     = 4'd2,
        KIND_NE     = 4'd3,
        KIND_NUMBER = 4'd4,
        KIND_IDENT  = 4'd5,
        KIND_STRING = 4'd6,
        KIND_EOF    = 4'd7,
        KIND_ERROR  = 4'd8
    } t_kind;

    typedef enum logic [3:0] {
        MODE_IDLE  = 4'd0,
        MODE_PEQ   = 4'd1,
        MODE_PNE   = 4'd2,
        MODE_STR   = 4'd3,
        MODE_IDENT = 4'd4,
        MODE_ZERO  = 4'd5,
        MODE_OCT   = 4'd6,
        MODE_DEC   = 4'd7,
        MODE_ZX    = 4'd8,
        MODE_ZXU   = 4'd9,
        MODE_HEX   = 4'd10,
        MODE_STOP  = 4'd11
    } t_mode;

    typedef struct packed {
        t_kind       kind;
        logic [31:0] value;
    } t_rec;

endpackage

/* hw/rtl/csl_front.sv */
// Front end of the C subset lexer: takes one source byte per request, runs the
// mode machine and the line and column counters, and writes at most one bundle of results.
// Depends on csl_pkg.
module csl_front #(
    parameter int LINE_BITS   = 16,
    parameter int COLUMN_BITS = 12
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic                                          i_accept,
    input  logic [7:0]                                    i_text_byte,
    output logic                                          o_wr,
    output csl_pkg::t_rec [csl_pkg::MAX_RESULTS-1:0]      o_recs,
    output logic [csl_pkg::MAX_RESULTS-1:0][COLUMN_BITS-1:0] o_cols,
    output logic [LINE_BITS-1:0]                          o_line,
    output logic [csl_pkg::RES_IDX_BITS-1:0]              o_last_idx
);
    import csl_pkg::*;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_X_LO  = 8'h78;
    localparam logic [7:0] CH_X_UP  = 8'h58;

    localparam logic [COLUMN_BITS-1:0] COL_MAX  = '1;
    localparam logic [LINE_BITS-1:0]   LINE_MAX = '1;

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= 8'h30) && (b <= 8'h39);
    endfunction

    function automatic logic is_octal(input logic [7:0] b);
        return (b >= 8'h30) && (b <= 8'h37);
    endfunction

    function automatic logic is_alpha(input logic [7:0] b);
        return ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A));
    endfunction

    function automatic logic is_space(input logic [7:0] b);
        return (b == CH_SPACE) || ((b >= 8'h09) && (b <= 8'h0D));
    endfunction

    function automatic logic is_punct(input logic [7:0] b);
        logic hit;
        case (b)
            8'h2B, 8'h2D, 8'h26, 8'h5E, 8'h7C, 8'h2A, 8'h2F,
            8'h28, 8'h29, 8'h7B, 8'h7D, 8'h2C, 8'h3B: hit = 1'b1;
            default:                                  hit = 1'b0;
        endcase
        return hit;
    endfunction

    // Bit 4 flags a hex digit, the low nibble is its value.
    function automatic logic [4:0] hex_val(input logic [7:0] b);
        logic [4:0] h;
        if (is_digit(b)) begin
            h = {1'b1, b[3:0]};
        end else if (((b >= 8'h61) && (b <= 8'h66)) || ((b >= 8'h41) && (b <= 8'h46))) begin
            h = {1'b1, 4'(b[3:0] + 4'd9)};
        end else begin
            h = 5'd0;
        end
        return h;
    endfunction

    t_mode                  r_mode, n_mode;
    logic [31:0]            r_accum, n_accum;
    logic [LINE_BITS-1:0]   r_line, n_line;
    logic [COLUMN_BITS-1:0] r_col, n_col;
    logic [COLUMN_BITS-1:0] r_start, n_start;

    t_rec [MAX_RESULTS-1:0]                  recs;
    logic [MAX_RESULTS-1:0][COLUMN_BITS-1:0] cols;
    logic [RES_IDX_BITS:0]                   cnt;
    logic                                    go_fresh;
    logic                                    go_ident;
    logic                                    newline;
    logic                                    stopped;
    logic [4:0]                              hex;
    logic [31:0]                             digit;

    assign hex   = hex_val(i_text_byte);
    assign digit = {28'd0, i_text_byte[3:0]};

    always_comb begin
        n_mode   = r_mode;
        n_accum  = r_accum;
        n_start  = r_start;
        n_line   = r_line;
        n_col    = r_col;
        recs     = '0;
        cols     = '0;
        cnt      = '0;
        go_fresh = 1'b0;
        go_ident = 1'b0;
        newline  = 1'b0;
        stopped  = (r_mode == MODE_STOP);

        unique case (r_mode)
            MODE_IDLE: begin
                go_fresh = 1'b1;
            end
            MODE_PEQ: begin
                n_mode = MODE_IDLE;
                if (i_text_byte == CH_EQ) begin
                    recs[cnt[RES_IDX_BITS-1:0]] = '{kind: KIND_EQ, value: 32'd0};
                    cols[cnt[RES_IDX_BITS-1:0]] = r_start;
                    cnt = cnt + 1'b1;
                end else begin
                    recs[cnt[RES_IDX_BITS-1:0]] = '{kind: KIND_PUNCT, value: {24'd0, CH_EQ}};
                    cols[cnt[RES_IDX_BITS-1:0]] = r_start;
                    cnt = cnt + 1'b1;
                    go_fresh = 1'b1;
                end
            end
            MODE_PNE: begin
                if (i_text_byte == CH_EQ) begin
                    recs[cnt[RES_IDX_BITS-1:0]] = '{kind: KIND_NE, value: 32'd0};
                    n_mode = MODE_IDLE;
                end else begin
                    recs[cnt[RES_IDX_BITS-1:0]] = '{kind: KIND_ERROR, value: {24'd0, CH_BANG}};
                    n_mode = MODE_STOP;
                end
                cols[cnt[RES_IDX_BITS-1:0]] = r_start;
                cnt = cnt + 1'b1;
            end
            MODE_STR: begin
                if (i_text_byte == CH_QUOTE) begin
                    recs[cnt[RES_IDX_BITS-1:0]] = '{kind: KIND_STRING, value: 32'd0};
                    n_mode = MODE_IDLE;
                end else if (i_text_byte == CH_NUL) begin
                    recs[cnt[RES_IDX_BITS-1:0]] = '{kind: KIND_ERROR, value: 32'd0};
                    n_mode = MODE_STOP;
                end else begin
                    recs[cnt[RES_IDX_BITS-1:0]] = '{kind: KIND_TEXT, value: {24'd0, i_text_byte}};
                end
                cols[cnt[RES_IDX_BITS-1:0]] = r_start;
                cnt = cnt + 1'b1;
            end
            MODE_IDENT: begin
                go_ident = 1'b1;
            end
            MODE_ZERO: begin
                if (is_octal(i_text_byte)) begin
                    n_accum = digit;
                    n_mode  = MODE_OCT;
                end else if (i_text_byte == CH_X_LO) begin
                    n_mode = MODE_ZX;
                end else if (i_text_byte == CH_X_UP) begin
                    n_mode = MODE_ZXU;
                end else begin
                    recs[cnt[RES_IDX_BITS-1:0]] = '{kind: KIND_NUMBER, value: r_accum};
                    cols[cnt[RES_IDX_BITS-1:0]] = r_start;
                    cnt = cnt + 1'b1;
                    n_mode = MODE_IDLE;
                    go_fresh = 1'b1;
                end
            end
            MODE_OCT: begin
                if (is_octal(i_text_byte)) begin
                    n_accum = {r_accum[28:0], 3'd0} + digit;
                end else begin
                    recs[cnt[RES_IDX_BITS-1:0]] = '{kind: KIND_NUMBER, value: r_accum};
                    cols[cnt[RES_IDX_BITS-1:0]] = r_start;
                    cnt = cnt + 1'b1;
                    n_mode = MODE_IDLE;
                    go_fresh = 1'b1;
                end
            end
            MODE_DEC: begin
                if (is_digit(i_text_byte)) begin
                    n_accum = {r_accum[28:0], 3'd0} + {r_accum[30:0], 1'b0} + digit;
                end else begin
                    recs[cnt[RES_IDX_BITS-1:0]] = '{kind: KIND_NUMBER, value: r_accum};
                    cols[cnt[RES_IDX_BITS-1:0]] = r_start;
                    cnt = cnt + 1'b1;
                    n_mode = MODE_IDLE;
                    go_fresh = 1'b1;
                end
            end
            MODE_ZX, MODE_ZXU: begin
                if (hex[4]) begin
                    n_accum = {28'd0, hex[3:0]};
                    n_mode  = MODE_HEX;
                end else begin
                    // A bare prefix: the zero is a number and the x opens an identifier.
                    recs[cnt[RES_IDX_BITS-1:0]] = '{kind: KIND_NUMBER, value: 32'd0};
                    cols[cnt[RES_IDX_BITS-1:0]] = r_start;
                    cnt = cnt + 1'b1;
                    n_start = (r_start != COL_MAX) ? r_start + 1'b1 : r_start;
                    recs[cnt[RES_IDX_BITS-1:0]] = '{kind: KIND_TEXT,
                        value: {24'd0, (r_mode == MODE_ZX) ? CH_X_LO : CH_X_UP}};
                    cols[cnt[RES_IDX_BITS-1:0]] = n_start;
                    cnt = cnt + 1'b1;
                    n_mode = MODE_IDENT;
                    go_ident = 1'b1;
                end
            end
            MODE_HEX: begin
                if (hex[4]) begin
                    n_accum = {r_accum[27:0], hex[3:0]};
                end else begin
                    recs[cnt[RES_IDX_BITS-1:0]] = '{kind: KIND_NUMBER, value: r_accum};
                    cols[cnt[RES_IDX_BITS-1:0]] = r_start;
                    cnt = cnt + 1'b1;
                    n_mode = MODE_IDLE;
                    go_fresh = 1'b1;
                end
            end
            MODE_STOP: begin
                n_mode = MODE_STOP;
            end
            default: begin
                n_mode = MODE_STOP;
            end
        endcase

        if (go_ident) begin
            if (is_alpha(i_text_byte) || is_digit(i_text_byte)) begin
                recs[cnt[RES_IDX_BITS-1:0]] = '{kind: KIND_TEXT, value: {24'd0, i_text_byte}};
                cols[cnt[RES_IDX_BITS-1:0]] = n_start;
                cnt = cnt + 1'b1;
            end else begin
                recs[cnt[RES_IDX_BITS-1:0]] = '{kind: KIND_IDENT, value: 32'd0};
                cols[cnt[RES_IDX_BITS-1:0]] = n_start;
                cnt = cnt + 1'b1;
                n_mode = MODE_IDLE;
                go_fresh = 1'b1;
            end
        end

        // A byte seen with no token open.
        if (go_fresh) begin
            if (i_text_byte == CH_NUL) begin
                recs[cnt[RES_IDX_BITS-1:0]] = '{kind: KIND_EOF, value: 32'd0};
                cols[cnt[RES_IDX_BITS-1:0]] = n_start;
                cnt = cnt + 1'b1;
                n_mode = MODE_STOP;
            end else if (i_text_byte == CH_NL) begin
                newline = 1'b1;
            end else if (!is_space(i_text_byte)) begin
                n_start = r_col;
                if (i_text_byte == CH_EQ) begin
                    n_mode = MODE_PEQ;
                end else if (i_text_byte == CH_BANG) begin
                    n_mode = MODE_PNE;
                end else if (i_text_byte == CH_QUOTE) begin
                    n_mode = MODE_STR;
                end else if (is_punct(i_text_byte)) begin
                    recs[cnt[RES_IDX_BITS-1:0]] = '{kind: KIND_PUNCT, value: {24'd0, i_text_byte}};
                    cols[cnt[RES_IDX_BITS-1:0]] = r_col;
                    cnt = cnt + 1'b1;
                end else if (is_alpha(i_text_byte)) begin
                    recs[cnt[RES_IDX_BITS-1:0]] = '{kind: KIND_TEXT, value: {24'd0, i_text_byte}};
                    cols[cnt[RES_IDX_BITS-1:0]] = r_col;
                    cnt = cnt + 1'b1;
                    n_mode = MODE_IDENT;
                end else if (i_text_byte == CH_ZERO) begin
                    n_accum = 32'd0;
                    n_mode  = MODE_ZERO;
                end else if (is_digit(i_text_byte)) begin
                    n_accum = digit;
                    n_mode  = MODE_DEC;
                end else begin
                    recs[cnt[RES_IDX_BITS-1:0]] = '{kind: KIND_ERROR, value: {24'd0, i_text_byte}};
                    cols[cnt[RES_IDX_BITS-1:0]] = r_col;
                    cnt = cnt + 1'b1;
                    n_mode = MODE_STOP;
                end
            end
        end

        if (!stopped) begin
            if (newline) begin
                n_line = (r_line != LINE_MAX) ? r_line + 1'b1 : r_line;
                n_col  = '0;
            end else begin
                n_col = (r_col != COL_MAX) ? r_col + 1'b1 : r_col;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_IDLE;
            r_accum <= '0;
            r_line  <= '0;
            r_col   <= '0;
            r_start <= '0;
        end else if (i_accept) begin
            r_mode  <= n_mode;
            r_accum <= n_accum;
            r_line  <= n_line;
            r_col   <= n_col;
            r_start <= n_start;
        end
    end

    assign o_wr       = i_accept && (cnt != '0);
    assign o_recs     = recs;
    assign o_cols     = cols;
    assign o_line     = r_line;
    assign o_last_idx = RES_IDX_BITS'(cnt - 1'b1);

endmodule

/* hw/rtl/csl_queue.sv */
// Short queue of result bundles between the lexer front end and the back end.
// Each entry holds up to four results that one source byte produced.
// Depends on csl_pkg.
module csl_queue #(
    parameter int LINE_BITS   = 16,
    parameter int COLUMN_BITS = 12
) (
    input  logic                                             i_clk,
    input  logic                                             i_rst_n,
    input  logic                                             i_wr,
    input  csl_pkg::t_rec [csl_pkg::MAX_RESULTS-1:0]         i_recs,
    input  logic [csl_pkg::MAX_RESULTS-1:0][COLUMN_BITS-1:0] i_cols,
    input  logic [LINE_BITS-1:0]                             i_line,
    input  logic [csl_pkg::RES_IDX_BITS-1:0]                 i_last_idx,
    output logic                                             o_full,
    input  logic                                             i_rd,
    output logic                                             o_empty,
    output csl_pkg::t_rec [csl_pkg::MAX_RESULTS-1:0]         o_recs,
    output logic [csl_pkg::MAX_RESULTS-1:0][COLUMN_BITS-1:0] o_cols,
    output logic [LINE_BITS-1:0]                             o_line,
    output logic [csl_pkg::RES_IDX_BITS-1:0]                 o_last_idx
);
    import csl_pkg::*;

    localparam int PTR_BITS = $clog2(QUEUE_DEPTH);

    t_rec [MAX_RESULTS-1:0]                  r_recs [QUEUE_DEPTH];
    logic [MAX_RESULTS-1:0][COLUMN_BITS-1:0] r_cols [QUEUE_DEPTH];
    logic [LINE_BITS-1:0]                    r_line [QUEUE_DEPTH];
    logic [RES_IDX_BITS-1:0]                 r_last [QUEUE_DEPTH];

    logic [PTR_BITS-1:0] r_wr_ptr;
    logic [PTR_BITS-1:0] r_rd_ptr;
    logic [PTR_BITS:0]   r_count;
    logic                do_wr;
    logic                do_rd;

    assign o_full  = (r_count == (PTR_BITS+1)'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign do_wr   = i_wr && !o_full;
    assign do_rd   = i_rd && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_wr) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_rd) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_wr && !do_rd) begin
                r_count <= r_count + 1'b1;
            end else if (do_rd && !do_wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_recs[r_wr_ptr] <= i_recs;
            r_cols[r_wr_ptr] <= i_cols;
            r_line[r_wr_ptr] <= i_line;
            r_last[r_wr_ptr] <= i_last_idx;
        end
    end

    assign o_recs     = r_recs[r_rd_ptr];
    assign o_cols     = r_cols[r_rd_ptr];
    assign o_line     = r_line[r_rd_ptr];
    assign o_last_idx = r_last[r_rd_ptr];

endmodule

/* hw/rtl/csl_back.sv */
// Back end of the C subset lexer: unpacks the bundle at the head of the queue one
// result per cycle into the output register while the receiver pops or the register is empty.
// Depends on csl_pkg.
module csl_back #(
    parameter int LINE_BITS   = 16,
    parameter int COLUMN_BITS = 12
) (
    input  logic                                             i_clk,
    input  logic                                             i_rst_n,
    input  logic                                             i_q_empty,
    input  csl_pkg::t_rec [csl_pkg::MAX_RESULTS-1:0]         i_recs,
    input  logic [csl_pkg::MAX_RESULTS-1:0][COLUMN_BITS-1:0] i_cols,
    input  logic [LINE_BITS-1:0]                             i_line,
    input  logic [csl_pkg::RES_IDX_BITS-1:0]                 i_last_idx,
    output logic                                             o_q_rd,
    input  logic                                             i_pop,
    output logic                                             o_empty,
    output logic [3:0]                                       o_token_kind,
    output logic [31:0]                                      o_token_value,
    output logic [LINE_BITS-1:0]                             o_token_line,
    output logic [COLUMN_BITS-1:0]                           o_token_column,
    output logic                                             o_last_of_run
);
    import csl_pkg::*;

    logic [RES_IDX_BITS-1:0] r_idx;
    logic                    r_valid;
    t_rec                    r_rec;
    logic [LINE_BITS-1:0]    r_line;
    logic [COLUMN_BITS-1:0]  r_column;
    logic                    r_last;
    logic                    load;
    logic                    at_last;

    assign load    = !i_q_empty && (!r_valid || i_pop);
    assign at_last = (r_idx == i_last_idx);
    assign o_q_rd  = load && at_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_idx   <= at_last ? '0 : r_idx + 1'b1;
            end else if (i_pop) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_rec    <= i_recs[r_idx];
            r_column <= i_cols[r_idx];
            r_line   <= i_line;
            r_last   <= at_last;
        end
    end

    assign o_empty        = !r_valid;
    assign o_token_kind   = r_rec.kind;
    assign o_token_value  = r_rec.value;
    assign o_token_line   = r_line;
    assign o_token_column = r_column;
    assign o_last_of_run  = r_last;

endmodule

/* hw/rtl/c_subset_lexer.sv */
// Top level of the C subset lexer: front end, bundle queue and back end.
// Depends on csl_pkg, csl_front, csl_queue and csl_back.
//
// Usage. Source text enters as one byte per request on the input queue port: a byte
// on i_text_byte is taken at a rising edge where push is high and full is low. A
// zero byte ends the text. Tokens leave through the output queue port: while empty
// is low the oldest result sits on the o_token_* ports and o_last_of_run, and it is
// taken at a rising edge where pop is high.
//
// Timing. The front end lexes a byte in the cycle it is taken, so one byte is
// accepted per cycle while full is low. A byte yields zero to four results, stored
// as one bundle in a four-entry queue; the back end hands them out one per cycle
// while the receiver pops. Each result passes the queue and the output register.
// The output port delivers at most one result per cycle, so bytes that yield several
// results fill the queue, and full then rises until the back end has caught up.
//
// Stalls and reset. If the receiver stops popping, the output register holds its
// result and the queue absorbs up to four further bundles before full is raised.
// After an error or end-of-text token the lexer swallows every byte until reset.
// Reset clears the lexer mode and the line and column counters and empties the queue
// and the output register; no clearing pass is needed, and the block takes input in
// the first cycle after it.
module c_subset_lexer #(
    parameter int LINE_BITS   = csl_pkg::LINE_BITS_DEF,
    parameter int COLUMN_BITS = csl_pkg::COLUMN_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   push,
    output logic                   full,
    input  logic [7:0]             i_text_byte,
    output logic                   empty,
    input  logic                   pop,
    output logic [3:0]             o_token_kind,
    output logic [31:0]            o_token_value,
    output logic [LINE_BITS-1:0]   o_token_line,
    output logic [COLUMN_BITS-1:0] o_token_column,
    output logic                   o_last_of_run
);
    import csl_pkg::*;

    // Bundle written by the front end.
    t_rec [MAX_RESULTS-1:0]                  wr_recs;
    logic [MAX_RESULTS-1:0][COLUMN_BITS-1:0] wr_cols;
    logic [LINE_BITS-1:0]                    wr_line;
    logic [RES_IDX_BITS-1:0]                 wr_last_idx;
    logic                                    wr_en;

    // Bundle at the head of the queue.
    t_rec [MAX_RESULTS-1:0]                  rd_recs;
    logic [MAX_RESULTS-1:0][COLUMN_BITS-1:0] rd_cols;
    logic [LINE_BITS-1:0]                    rd_line;
    logic [RES_IDX_BITS-1:0]                 rd_last_idx;
    logic                                    rd_en;
    logic                                    q_empty;
    logic                                    q_full;
    logic                                    accept;

    // The queue is the only thing that can hold the front end back.
    assign full   = q_full;
    assign accept = push && !q_full;

    csl_front #(
        .LINE_BITS   (LINE_BITS),
        .COLUMN_BITS (COLUMN_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_text_byte (i_text_byte),
        .o_wr        (wr_en),
        .o_recs      (wr_recs),
        .o_cols      (wr_cols),
        .o_line      (wr_line),
        .o_last_idx  (wr_last_idx)
    );

    csl_queue #(
        .LINE_BITS   (LINE_BITS),
        .COLUMN_BITS (COLUMN_BITS)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr       (wr_en),
        .i_recs     (wr_recs),
        .i_cols     (wr_cols),
        .i_line     (wr_line),
        .i_last_idx (wr_last_idx),
        .o_full     (q_full),
        .i_rd       (rd_en),
        .o_empty    (q_empty),
        .o_recs     (rd_recs),
        .o_cols     (rd_cols),
        .o_line     (rd_line),
        .o_last_idx (rd_last_idx)
    );

    csl_back #(
        .LINE_BITS   (LINE_BITS),
        .COLUMN_BITS (COLUMN_BITS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_empty      (q_empty),
        .i_recs         (rd_recs),
        .i_cols         (rd_cols),
        .i_line         (rd_line),
        .i_last_idx     (rd_last_idx),
        .o_q_rd         (rd_en),
        .i_pop          (pop),
        .o_empty        (empty),
        .o_token_kind   (o_token_kind),
        .o_token_value  (o_token_value),
        .o_token_line   (o_token_line),
        .o_token_column (o_token_column),
        .o_last_of_run  (o_last_of_run)
    );

endmodule
